// ===== hw/rtl/julia_escape_time_defines.svh =====
// julia_escape_time_defines.svh: assertion macros for the Julia escape-time checker.
// No dependencies; included by jet_checker.sv.
`ifndef JULIA_ESCAPE_TIME_DEFINES_SVH
`define JULIA_ESCAPE_TIME_DEFINES_SVH

// Both macros clock on clk and are disabled while rst_n is low, using the names
// of the enclosing scope.

// Same-cycle implication.
`define JET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/jet_pkg.sv =====
// jet_pkg.sv: types, constants and helper functions of the Julia escape-time block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jet_pkg;

    localparam int IMAGE_DIM = 4096;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 10;
    localparam int Q_W       = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_START    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

    localparam logic signed [Q_W-1:0] C_REAL_RST  = -32'sd268435456;
    localparam logic signed [Q_W-1:0] C_IMAG_RST  = 32'sd53687091;
    localparam logic signed [Q_W-1:0] X_START_RST = -32'sd268435456;
    localparam logic signed [Q_W-1:0] X_STEP_RST  = 32'sd838861;
    localparam logic signed [Q_W-1:0] Y_START_RST = -32'sd268435456;
    localparam logic signed [Q_W-1:0] Y_STEP_RST  = 32'sd1118481;
    localparam logic [CNT_W-1:0]      LIMIT_RST   = 10'd40;

    // 4.0 in Q8.56
    localparam logic [63:0] FOUR_Q856 = 64'h0400_0000_0000_0000;
    localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0] col_out;
        logic [IDX_W-1:0] row_out;
        logic [CNT_W-1:0] iter_count;
        logic             bounded;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_INIT,
        S_MUL,
        S_UPD,
        S_DONE
    } jet_state_t;

    typedef struct packed {
        logic capture;   // take the input beat, clear the counter
        logic setup;     // index times step
        logic init_z;    // start point into z
        logic mul;       // squares and cross product
        logic update;    // z = z*z + c, count one iteration
        logic load_out;  // park the result in the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic next_at_limit;
        logic escaped;
    } dp_status_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX64)
            r = Q_MAX64[Q_W-1:0];
        else if (v < Q_MIN64)
            r = Q_MIN64[Q_W-1:0];
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
        logic [16:0]      lim;
        logic [IDX_W-1:0] r;
        lim = 17'(IMAGE_DIM);
        if ({5'b0, v} >= lim)
            r = IDX_W'(IMAGE_DIM - 1);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/julia_escape_time.sv =====
// julia_escape_time.sv: top level of the Julia escape-time block.
// Depends on jet_pkg, jet_ctrl and jet_dpath.
`timescale 1ns / 1ps

// One pixel at a time: a beat on in_data is mapped to a Q4.28 start point and
// iterated as z = z*z + c until |z| reaches 2 or iter_limit iterations are done.
// The default limit is 40. Each iteration passes the multiply/update loop (S_MUL,
// S_UPD) around three 32x32 multipliers. The result sits in an output register,
// so the next beat is taken while it waits. Registers are written through
// cfg_we/cfg_index/cfg_data only while the block is idle: a rule for the user,
// which the block itself does not enforce.
module julia_escape_time
    import jet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    jet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    jet_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/jet_ctrl.sv =====
// jet_ctrl.sv: sequencing state machine and output-valid flag of the escape-time block.
// Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_ctrl
    import jet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    jet_state_t state_reg;
    jet_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SETUP;
            end
            S_SETUP: state_next = S_INIT;
            S_INIT:
            begin
                // zero limit: no iteration at all
                if (status.at_limit)
                    state_next = S_DONE;
                else
                    state_next = S_MUL;
            end
            S_MUL: state_next = S_UPD;
            S_UPD:
            begin
                if (status.escaped || status.next_at_limit)
                    state_next = S_DONE;
                else
                    state_next = S_MUL;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_SETUP: cmd.setup  = 1'b1;
            S_INIT:  cmd.init_z = 1'b1;
            S_MUL:   cmd.mul    = 1'b1;
            S_UPD:   cmd.update = !status.escaped;
            S_DONE:  cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/jet_dpath.sv =====
// jet_dpath.sv: configuration registers, start-point mapping, z iteration and result register.
// Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_dpath
    import jet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data,
    input  in_t                  in_data,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output out_t                 out_data
);

    logic signed [Q_W-1:0] c_real_reg;
    logic signed [Q_W-1:0] c_imag_reg;
    logic signed [Q_W-1:0] x_start_reg;
    logic signed [Q_W-1:0] x_step_reg;
    logic signed [Q_W-1:0] y_start_reg;
    logic signed [Q_W-1:0] y_step_reg;
    logic [CNT_W-1:0]      limit_reg;

    in_t                   pix_reg;
    logic [CNT_W-1:0]      iter_reg;
    logic [CNT_W-1:0]      iter_next;
    logic signed [44:0]    px_reg;
    logic signed [44:0]    py_reg;
    logic signed [44:0]    px_next;
    logic signed [44:0]    py_next;
    logic signed [Q_W-1:0] re_reg;
    logic signed [Q_W-1:0] im_reg;
    logic signed [63:0]    sr_reg;
    logic signed [63:0]    si_reg;
    logic signed [63:0]    pri_reg;
    logic signed [63:0]    sr_next;
    logic signed [63:0]    si_next;
    logic signed [63:0]    pri_next;
    logic signed [63:0]    re_start;
    logic signed [63:0]    im_start;
    logic signed [63:0]    re_sum;
    logic signed [63:0]    im_sum;
    logic [63:0]           mag_sq;
    out_t                  out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg  <= C_REAL_RST;
            c_imag_reg  <= C_IMAG_RST;
            x_start_reg <= X_START_RST;
            x_step_reg  <= X_STEP_RST;
            y_start_reg <= Y_START_RST;
            y_step_reg  <= Y_STEP_RST;
            limit_reg   <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_C_REAL:     c_real_reg  <= cfg_data;
                REG_C_IMAG:     c_imag_reg  <= cfg_data;
                REG_X_START:    x_start_reg <= cfg_data;
                REG_X_STEP:     x_step_reg  <= cfg_data;
                REG_Y_START:    y_start_reg <= cfg_data;
                REG_Y_STEP:     y_step_reg  <= cfg_data;
                REG_ITER_LIMIT: limit_reg   <= cfg_data[CNT_W-1:0];
                default:        limit_reg   <= limit_reg;
            endcase
        end
    end

    // start point: index * step, then add and saturate next cycle
    assign px_next  = $signed({1'b0, clamp_idx(pix_reg.col)}) * x_step_reg;
    assign py_next  = $signed({1'b0, clamp_idx(pix_reg.row)}) * y_step_reg;
    assign re_start = 64'(x_start_reg) + 64'(px_reg);
    assign im_start = 64'(y_start_reg) + 64'(py_reg);

    assign sr_next  = re_reg * re_reg;
    assign si_next  = im_reg * im_reg;
    assign pri_next = re_reg * im_reg;

    // both squares are at most 2^62, so the unsigned sum cannot wrap
    assign mag_sq = 64'(sr_reg) + 64'(si_reg);
    assign re_sum = ((sr_reg - si_reg) >>> 28) + 64'(c_real_reg);
    assign im_sum = (pri_reg >>> 27) + 64'(c_imag_reg);

    always_comb
    begin
        iter_next = iter_reg;
        if (cmd.capture)
            iter_next = '0;
        else if (cmd.update)
            iter_next = iter_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else
            iter_reg <= iter_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            pix_reg <= in_data;
        if (cmd.setup)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (cmd.init_z)
        begin
            re_reg <= sat_q(re_start);
            im_reg <= sat_q(im_start);
        end
        else if (cmd.update)
        begin
            re_reg <= sat_q(re_sum);
            im_reg <= sat_q(im_sum);
        end
        if (cmd.mul)
        begin
            sr_reg  <= sr_next;
            si_reg  <= si_next;
            pri_reg <= pri_next;
        end
        if (cmd.load_out)
        begin
            out_reg.col_out    <= pix_reg.col;
            out_reg.row_out    <= pix_reg.row;
            out_reg.iter_count <= iter_reg;
            out_reg.bounded    <= (iter_reg == limit_reg);
        end
    end

    assign status.at_limit      = (iter_reg == limit_reg);
    assign status.next_at_limit = ((iter_reg + CNT_W'(1)) == limit_reg);
    assign status.escaped       = (mag_sq >= FOUR_Q856);
    assign out_data             = out_reg;

endmodule

// ===== hw/rtl/jet_checker.sv =====
// jet_checker.sv: port-level assertions for julia_escape_time, bound to the top level.
// Depends on jet_pkg and julia_escape_time_defines.svh.
`timescale 1ns / 1ps
`include "julia_escape_time_defines.svh"

module jet_checker
    import jet_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [Q_W-1:0]       cfg_data,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_t                 out_data
);

    // shadow of the iteration limit, tracked from the config port
    logic [CNT_W-1:0] limit_reg;
    logic             in_beat;
    logic             out_stall;
    logic             out_bnd;
    logic             out_esc;
    logic             count_full;
    logic             count_short;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RST;
        else if (cfg_we && (cfg_index == REG_ITER_LIMIT))
            limit_reg <= cfg_data[CNT_W-1:0];
    end

    assign in_beat     = in_valid && in_ready;
    assign out_stall   = out_valid && !out_ready;
    assign out_bnd     = out_valid && out_data.bounded;
    assign out_esc     = out_valid && !out_data.bounded;
    assign count_full  = (out_data.iter_count == limit_reg);
    assign count_short = (out_data.iter_count < limit_reg);

    `JET_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled beat changed")
    `JET_ASSERT_NEXT(a_busy_after_accept, in_beat, !in_ready, "input taken again right after a beat")
    `JET_ASSERT_NOW(a_bounded_count, out_bnd, count_full, "bounded result without full count")
    `JET_ASSERT_NOW(a_escaped_count, out_esc, count_short, "escaped result at or past limit")

endmodule

bind julia_escape_time jet_checker u_jet_checker (.*);

// ===== tb/sv/testbench.sv =====
// testbench.sv: self-checking bench for julia_escape_time, Julia escape-time per pixel.
// Depends on jet_pkg and the julia_escape_time RTL; directed table, then random views,
// each result checked against an escape-count predictor kept in this file or a result typed into the table.
`timescale 1ns / 1ps

module testbench;
    import jet_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 20000;
    localparam int ITEMS_PER_VIEW = 46;
    localparam int NUM_ROWS      = 58;

    typedef enum logic [1:0] {
        STEP_REG,        // register write
        STEP_PIX,        // pixel, result from the predictor
        STEP_PIX_KNOWN   // pixel, result typed into the row
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [Q_W-1:0]       data;
        in_t                  px;
        out_t                 res;
    } plan_row_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0] cfg_data;
    logic           in_valid;
    logic           in_ready;
    in_t            in_data;
    logic           out_valid;
    logic           out_ready;
    out_t           out_data;

    // shadow of the block's registers
    logic signed [Q_W-1:0] c_re, c_im, x_org, x_inc, y_org, y_inc;
    logic [CNT_W-1:0]      lim_shadow;

    out_t        pending_results [$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned errors;

    plan_row_t plan [NUM_ROWS] = '{
        '{STEP_PIX,       '0,             32'd0,         {12'd0,    12'd0},    '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd4095, 12'd4095}, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd2048, 12'd1365}, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd2730, 12'd2048}, '0},
        // no iterations at all
        '{STEP_REG,       REG_ITER_LIMIT, 32'd0,         '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd5,    12'd7}, {12'd5,    12'd7, 10'd0, 1'b1}},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd4095, 12'd0}, {12'd4095, 12'd0, 10'd0, 1'b1}},
        '{STEP_REG,       REG_ITER_LIMIT, 32'd1,         '0, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd2048, 12'd2048}, '0},
        // start point already outside radius 2, incl. saturated start
        '{STEP_REG,       REG_X_START,    32'h7FFF_FFFF, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd0,    12'd0},    {12'd0,    12'd0,    10'd0, 1'b0}},
        '{STEP_REG,       REG_X_START,    32'h8000_0000, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd0,    12'd4095}, {12'd0,    12'd4095, 10'd0, 1'b0}},
        '{STEP_REG,       REG_X_START,    32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_X_STEP,     32'h7FFF_FFFF, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd4095, 12'd100},  {12'd4095, 12'd100,  10'd0, 1'b0}},
        '{STEP_REG,       REG_X_STEP,     32'h8000_0000, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd4095, 12'd9},    {12'd4095, 12'd9,    10'd0, 1'b0}},
        '{STEP_REG,       REG_X_STEP,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_Y_START,    32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_Y_STEP,     32'h7FFF_FFFF, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd0,    12'd4095}, {12'd0,    12'd4095, 10'd0, 1'b0}},
        '{STEP_REG,       REG_Y_STEP,     32'h8000_0000, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd7,    12'd4095}, {12'd7,    12'd4095, 10'd0, 1'b0}},
        // z stuck at 0: runs the full limit
        '{STEP_REG,       REG_Y_STEP,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_C_REAL,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_C_IMAG,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_ITER_LIMIT, 32'd1023,      '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd123,  12'd456},  {12'd123,  12'd456, 10'd1023, 1'b1}},
        // extreme c: escapes right after the first iteration
        '{STEP_REG,       REG_C_REAL,     32'h7FFF_FFFF, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd3,    12'd4},    {12'd3,    12'd4,    10'd1, 1'b0}},
        '{STEP_REG,       REG_C_REAL,     32'h8000_0000, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd4,    12'd3},    {12'd4,    12'd3,    10'd1, 1'b0}},
        '{STEP_REG,       REG_C_REAL,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_C_IMAG,     32'h7FFF_FFFF, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd9,    12'd9},    {12'd9,    12'd9,    10'd1, 1'b0}},
        '{STEP_REG,       REG_C_IMAG,     32'h8000_0000, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd8,    12'd8},    {12'd8,    12'd8,    10'd1, 1'b0}},
        // |z|^2 exactly 4 escapes, one lsb below does not
        '{STEP_REG,       REG_C_IMAG,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_ITER_LIMIT, 32'd40,        '0, '0},
        '{STEP_REG,       REG_X_START,    32'h2000_0000, '0, '0},
        '{STEP_PIX_KNOWN, '0, 32'd0, {12'd0,    12'd0},    {12'd0,    12'd0,    10'd0, 1'b0}},
        '{STEP_REG,       REG_X_START,    32'h1FFF_FFFF, '0, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd0, 12'd0}, '0},
        // update saturates high, low, and on the imaginary part
        '{STEP_REG,       REG_C_REAL,     32'h7FFF_FFFF, '0, '0},
        '{STEP_REG,       REG_X_START,    32'h1F00_0000, '0, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd0, 12'd0}, '0},
        '{STEP_REG,       REG_X_START,    32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_Y_START,    32'h1F00_0000, '0, '0},
        '{STEP_REG,       REG_C_REAL,     32'h8000_0000, '0, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd0, 12'd0}, '0},
        '{STEP_REG,       REG_C_REAL,     32'h0000_0000, '0, '0},
        '{STEP_REG,       REG_X_START,    32'h1600_0000, '0, '0},
        '{STEP_REG,       REG_Y_START,    32'h1600_0000, '0, '0},
        '{STEP_REG,       REG_C_IMAG,     32'h7FFF_FFFF, '0, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd0, 12'd0}, '0},
        // write to an index with no register behind it
        '{STEP_REG,       REG_UNUSED,     32'hFFFF_FFFF, '0, '0},
        '{STEP_PIX,       '0,             32'd0,         {12'd100, 12'd200}, '0}
    };

    julia_escape_time DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clip_q(input longint v);
        if (v > Q_MAX64)
            return Q_MAX64;
        if (v < Q_MIN64)
            return Q_MIN64;
        return v;
    endfunction

    // escape count for one pixel under the current register shadow
    function automatic out_t escape_time(input in_t px);
        longint      cx, cy, re, im, sq_re, sq_im, nr, ni;
        int unsigned n;
        bit          gone;
        cx = (px.col >= IMAGE_DIM) ? IMAGE_DIM - 1 : px.col;
        cy = (px.row >= IMAGE_DIM) ? IMAGE_DIM - 1 : px.row;
        re = clip_q(longint'(x_org) + cx * longint'(x_inc));
        im = clip_q(longint'(y_org) + cy * longint'(y_inc));
        n = 0;
        gone = 1'b0;
        while (n < lim_shadow && !gone)
        begin
            sq_re = re * re;
            sq_im = im * im;
            // sum can reach 2^63, so compare unsigned
            if ($unsigned(sq_re) + $unsigned(sq_im) >= FOUR_Q856)
                gone = 1'b1;
            else
            begin
                nr = clip_q(((sq_re - sq_im) >>> 28) + longint'(c_re));
                ni = clip_q(((re * im) >>> 27) + longint'(c_im));
                re = nr;
                im = ni;
                n++;
            end
        end
        return '{col_out: px.col, row_out: px.row, iter_count: n[CNT_W-1:0],
                 bounded: (n == lim_shadow)};
    endfunction

    function automatic logic [Q_W-1:0] spread(input int unsigned half);
        return Q_W'($urandom_range(0, 2 * half)) - half;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // cfg_we is left high; the next beat or settle lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_C_REAL:     c_re = data;
            REG_C_IMAG:     c_im = data;
            REG_X_START:    x_org = data;
            REG_X_STEP:     x_inc = data;
            REG_Y_START:    y_org = data;
            REG_Y_STEP:     y_inc = data;
            REG_ITER_LIMIT: lim_shadow = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_pixel(input in_t px, input bit known, input out_t typed);
        if (cfg_we)
            cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(known ? typed : escape_time(px));
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        if (cfg_we)
            cfg_we <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: check each beat, then pick ready for the next cycle
    initial
    begin
        out_t  got;
        out_t  want;
        string diffs;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = out_data;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result beat %p", got));
                else
                begin
                    want = pending_results.pop_front();
                    diffs = "";
                    if (got.col_out !== want.col_out)
                        diffs = {diffs, $sformatf(" col_out %0d/%0d",
                                                  got.col_out, want.col_out)};
                    if (got.row_out !== want.row_out)
                        diffs = {diffs, $sformatf(" row_out %0d/%0d",
                                                  got.row_out, want.row_out)};
                    if (got.iter_count !== want.iter_count)
                        diffs = {diffs, $sformatf(" iter_count %0d/%0d",
                                                  got.iter_count, want.iter_count)};
                    if (got.bounded !== want.bounded)
                        diffs = {diffs, $sformatf(" bounded %0b/%0b",
                                                  got.bounded, want.bounded)};
                    if (diffs != "")
                        report_mismatch($sformatf("pixel (%0d,%0d):%s (got/exp)",
                                                  want.col_out, want.row_out, diffs));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat and no register write
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        in_t px;
        bit  last_pix;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        errors = 0;
        c_re       = C_REAL_RST;
        c_im       = C_IMAG_RST;
        x_org      = X_START_RST;
        x_inc      = X_STEP_RST;
        y_org      = Y_START_RST;
        y_inc      = Y_STEP_RST;
        lim_shadow = LIMIT_RST;
        send_idle_pct = 22;
        recv_idle_pct = 84;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        last_pix = 1'b1;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (plan[i].kind == STEP_REG)
            begin
                if (last_pix)
                    settle();
                write_reg(plan[i].idx, plan[i].data);
                last_pix = 1'b0;
            end
            else
            begin
                push_pixel(plan[i].px, plan[i].kind == STEP_PIX_KNOWN, plan[i].res);
                last_pix = 1'b1;
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 22 : 0;
            for (int s = 0; s < 4; s++)
            begin
                settle();
                if (s == 3)
                begin
                    // raw register noise: mostly saturated starts and instant escapes
                    for (int r = REG_C_REAL; r <= REG_Y_STEP; r++)
                        write_reg(CFG_IDX_W'(r), $urandom());
                    write_reg(REG_ITER_LIMIT, $urandom_range(0, 1023));
                end
                else
                begin
                    // a frame of up to 4x4 around the set, c near the interesting region
                    write_reg(REG_C_REAL, spread(32'h1800_0000));
                    write_reg(REG_C_IMAG, spread(32'h1000_0000));
                    write_reg(REG_X_START, spread(32'h2800_0000));
                    write_reg(REG_X_STEP, spread(32'h0004_0000));
                    write_reg(REG_Y_START, spread(32'h2800_0000));
                    write_reg(REG_Y_STEP, spread(32'h0004_0000));
                    write_reg(REG_ITER_LIMIT, (s == 1) ? $urandom_range(200, 1023)
                                                       : $urandom_range(0, 64));
                end
                for (int k = 0; k < ITEMS_PER_VIEW; k++)
                begin
                    px.col = IDX_W'($urandom_range(4095));
                    px.row = IDX_W'($urandom_range(4095));
                    push_pixel(px, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/jet_pkg.sv
hw/rtl/jet_ctrl.sv
hw/rtl/jet_dpath.sv
hw/rtl/julia_escape_time.sv
hw/rtl/jet_checker.sv
tb/sv/testbench.sv
